@@ sv/bdlw_pkg.sv @@
// Shared types, codes and the glyph font table for the big-digit LCD writer.
package bdlw_pkg;

	localparam int MAX_DIGITS = 8;
	localparam int NUM_WIDTH = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_WIDTH = 4 * BCD_DIGITS;

	localparam logic [3:0] GLYPH_BLANK = 4'd10;
	localparam logic [3:0] GLYPH_PCT = 4'd11;
	localparam logic [3:0] GLYPH_MINUS = 4'd12;
	localparam logic [7:0] SPACE_CODE = 8'd32;

	localparam logic [2:0] REG_FONT = 3'd0;
	localparam logic [2:0] REG_NUM_COL = 3'd1;
	localparam logic [2:0] REG_NUM_CNT = 3'd2;
	localparam logic [2:0] REG_SYM_COL = 3'd3;
	localparam logic [2:0] REG_SYM_CNT = 3'd4;

	localparam logic [1:0] KIND_EXPLICIT = 2'd0;
	localparam logic [1:0] KIND_NUMBER = 2'd1;
	localparam logic [1:0] KIND_SYMBOL = 2'd2;

	// Codes per font, glyph and cell (upper-left, lower-left, upper-right, lower-right).
	localparam logic [0:3][0:12][0:3][7:0] FONT_ROM = '{
		'{ '{8'd5, 8'd255, 8'd7, 8'd6}, '{8'd0, 8'd2, 8'd1, 8'd255},
		   '{8'd0, 8'd255, 8'd3, 8'd2}, '{8'd0, 8'd2, 8'd3, 8'd255},
		   '{8'd1, 8'd0, 8'd255, 8'd1}, '{8'd4, 8'd2, 8'd0, 8'd255},
		   '{8'd5, 8'd4, 8'd0, 8'd255}, '{8'd0, 8'd32, 8'd255, 8'd1},
		   '{8'd255, 8'd4, 8'd3, 8'd255}, '{8'd255, 8'd2, 8'd3, 8'd6},
		   '{8'd32, 8'd32, 8'd32, 8'd32}, '{8'd255, 8'd47, 8'd47, 8'd255},
		   '{8'd2, 8'd32, 8'd2, 8'd32} },
		'{ '{8'd5, 8'd7, 8'd255, 8'd6}, '{8'd0, 8'd2, 8'd1, 8'd7},
		   '{8'd0, 8'd4, 8'd3, 8'd2}, '{8'd0, 8'd2, 8'd3, 8'd3},
		   '{8'd1, 8'd0, 8'd1, 8'd5}, '{8'd4, 8'd2, 8'd0, 8'd3},
		   '{8'd5, 8'd4, 8'd0, 8'd3}, '{8'd0, 8'd32, 8'd3, 8'd1},
		   '{8'd4, 8'd4, 8'd3, 8'd3}, '{8'd4, 8'd2, 8'd3, 8'd6},
		   '{8'd32, 8'd32, 8'd32, 8'd32}, '{8'd219, 8'd47, 8'd47, 8'd219},
		   '{8'd2, 8'd32, 8'd2, 8'd32} },
		'{ '{8'd5, 8'd7, 8'd6, 8'd5}, '{8'd0, 8'd2, 8'd1, 8'd7},
		   '{8'd0, 8'd4, 8'd3, 8'd2}, '{8'd0, 8'd2, 8'd3, 8'd3},
		   '{8'd1, 8'd0, 8'd7, 8'd1}, '{8'd4, 8'd2, 8'd0, 8'd3},
		   '{8'd5, 8'd4, 8'd32, 8'd3}, '{8'd0, 8'd5, 8'd3, 8'd32},
		   '{8'd4, 8'd4, 8'd3, 8'd3}, '{8'd4, 8'd32, 8'd3, 8'd5},
		   '{8'd32, 8'd32, 8'd32, 8'd32}, '{8'd111, 8'd5, 8'd5, 8'd111},
		   '{8'd2, 8'd32, 8'd2, 8'd32} },
		'{ '{8'd5, 8'd7, 8'd6, 8'd5}, '{8'd0, 8'd2, 8'd1, 8'd7},
		   '{8'd0, 8'd5, 8'd3, 8'd2}, '{8'd0, 8'd2, 8'd3, 8'd3},
		   '{8'd5, 8'd0, 8'd7, 8'd1}, '{8'd7, 8'd2, 8'd0, 8'd3},
		   '{8'd5, 8'd4, 8'd32, 8'd3}, '{8'd0, 8'd5, 8'd3, 8'd32},
		   '{8'd4, 8'd4, 8'd3, 8'd3}, '{8'd4, 8'd32, 8'd3, 8'd5},
		   '{8'd32, 8'd32, 8'd32, 8'd32}, '{8'd242, 8'd47, 8'd47, 8'd242},
		   '{8'd2, 8'd32, 8'd2, 8'd32} }
	};

	typedef struct packed {
		logic [1:0] kind;
		logic signed [31:0] number;
		logic [3:0] digit_count;
		logic [7:0] start_column;
		logic show_percent;
	} in_t;

	typedef struct packed {
		logic [7:0] column;
		logic row;
		logic [7:0] char_code;
		logic last_write;
	} out_t;

	typedef enum logic [2:0] {
		OP_SIGN,
		OP_DIGIT,
		OP_REPEAT,
		OP_PCT,
		OP_GAP
	} op_t;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic emit;
		op_t op;
		logic [2:0] idx;
		logic [1:0] sub;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic sign_draw;
		logic mag_zero;
		logic pct;
		logic last_digit;
		logic gaps_none;
		logic sc_zero;
		logic out_free;
	} status_t;

endpackage

@@ sv/bdlw_datapath.sv @@
// Datapath: configuration, item registers, binary to BCD conversion and cell write output.
module bdlw_datapath (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [2:0] cfg_index,
	input logic [7:0] cfg_data,
	input bdlw_pkg::in_t in_data,
	input bdlw_pkg::cmd_t cmd,
	output bdlw_pkg::status_t status,
	output logic out_valid,
	input logic out_stall,
	output bdlw_pkg::out_t out_data
);

	logic [1:0] font_q;
	logic [7:0] num_col_q;
	logic [3:0] num_cnt_q;
	logic [7:0] sym_col_q;
	logic [3:0] sym_cnt_q;
	logic last_neg_q;
	logic [7:0] last_sc_q;

	logic [3:0] n_q;
	logic [7:0] sc_q;
	logic pct_q;
	logic mag_zero_q;
	logic sign_draw_q;
	logic [7:0] sign_col_q;
	logic [3:0] sign_glyph_q;
	logic [bdlw_pkg::NUM_WIDTH-1:0] mag_q;
	logic [bdlw_pkg::BCD_WIDTH-1:0] bcd_q;
	logic out_valid_q;
	bdlw_pkg::out_t out_q;

	logic [3:0] n_raw;
	logic [3:0] n_sel;
	logic [7:0] sc_sel;
	logic pct_sel;
	logic neg;
	logic [bdlw_pkg::NUM_WIDTH-1:0] mag_in;
	logic [bdlw_pkg::BCD_WIDTH-1:0] bcd_adj;
	logic [bdlw_pkg::MAX_DIGITS-1:0] hi_zero;
	logic [3:0] k_full;
	logic [2:0] k;
	logic [3:0] digit;
	logic [7:0] digit_col;
	logic [7:0] pct_col;
	logic [7:0] base_col;
	logic [3:0] glyph;
	bdlw_pkg::out_t out_next;

	// Item selection on load.
	always_comb begin
		case (in_data.kind)
			bdlw_pkg::KIND_NUMBER: begin
				n_raw = num_cnt_q;
				sc_sel = num_col_q;
				pct_sel = 1'b0;
			end
			bdlw_pkg::KIND_SYMBOL: begin
				n_raw = sym_cnt_q;
				sc_sel = sym_col_q;
				pct_sel = in_data.show_percent;
			end
			default: begin
				n_raw = in_data.digit_count;
				sc_sel = in_data.start_column;
				pct_sel = in_data.show_percent;
			end
		endcase
		if (n_raw == 4'd0) begin
			n_sel = 4'd1;
		end else if (n_raw > 4'(bdlw_pkg::MAX_DIGITS)) begin
			n_sel = 4'(bdlw_pkg::MAX_DIGITS);
		end else begin
			n_sel = n_raw;
		end
		neg = in_data.number[31];
		mag_in = neg ? (32'd0 - in_data.number) : in_data.number;
	end

	// Shift-and-add-three step: each BCD digit of five or more gets three added before the shift.
	always_comb begin
		for (int j = 0; j < bdlw_pkg::BCD_DIGITS; j++) begin
			if (bcd_q[4*j +: 4] >= 4'd5) begin
				bcd_adj[4*j +: 4] = bcd_q[4*j +: 4] + 4'd3;
			end else begin
				bcd_adj[4*j +: 4] = bcd_q[4*j +: 4];
			end
		end
	end

	// A digit is blanked when it and every higher digit of the full magnitude are zero.
	always_comb begin
		for (int j = 0; j < bdlw_pkg::MAX_DIGITS; j++) begin
			hi_zero[j] = ((bcd_q >> (4 * j)) == '0);
		end
	end

	always_comb begin
		k_full = n_q - 4'd1 - {1'b0, cmd.idx};
		k = k_full[2:0];
		digit = bcd_q[4*k +: 4];
		digit_col = sc_q + ({5'd0, cmd.idx} << 1) + {5'd0, cmd.idx};
		pct_col = sc_q + ({4'd0, n_q} << 1) + {4'd0, n_q};
		case (cmd.op)
			bdlw_pkg::OP_SIGN: begin
				base_col = sign_col_q;
				glyph = sign_glyph_q;
			end
			bdlw_pkg::OP_DIGIT: begin
				base_col = digit_col;
				glyph = hi_zero[k] ? bdlw_pkg::GLYPH_BLANK : digit;
			end
			bdlw_pkg::OP_REPEAT: begin
				base_col = digit_col;
				glyph = digit;
			end
			bdlw_pkg::OP_PCT: begin
				base_col = pct_col;
				glyph = bdlw_pkg::GLYPH_PCT;
			end
			default: begin
				base_col = digit_col - 8'd1;
				glyph = bdlw_pkg::GLYPH_BLANK;
			end
		endcase
		out_next.row = cmd.sub[0];
		out_next.last_write = cmd.last;
		if (cmd.op == bdlw_pkg::OP_GAP) begin
			out_next.column = base_col;
			out_next.char_code = bdlw_pkg::SPACE_CODE;
		end else begin
			out_next.column = base_col + {7'd0, cmd.sub[1]};
			out_next.char_code = bdlw_pkg::FONT_ROM[font_q][glyph][cmd.sub];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_q <= 2'd0;
			num_col_q <= 8'd3;
			num_cnt_q <= 4'd4;
			sym_col_q <= 8'd3;
			sym_cnt_q <= 4'd3;
			last_neg_q <= 1'b0;
			last_sc_q <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					bdlw_pkg::REG_FONT: font_q <= cfg_data[1:0];
					bdlw_pkg::REG_NUM_COL: num_col_q <= cfg_data;
					bdlw_pkg::REG_NUM_CNT: num_cnt_q <= cfg_data[3:0];
					bdlw_pkg::REG_SYM_COL: sym_col_q <= cfg_data;
					bdlw_pkg::REG_SYM_CNT: sym_cnt_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				last_neg_q <= neg;
				last_sc_q <= sc_sel;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= n_sel;
			sc_q <= sc_sel;
			pct_q <= pct_sel;
			mag_zero_q <= (mag_in == '0);
			mag_q <= mag_in;
			bcd_q <= '0;
			// A negative number draws its minus; a positive one after a negative erases the old minus.
			sign_draw_q <= neg | last_neg_q;
			sign_col_q <= (neg ? sc_sel : last_sc_q) - 8'd3;
			sign_glyph_q <= neg ? bdlw_pkg::GLYPH_MINUS : bdlw_pkg::GLYPH_BLANK;
		end else if (cmd.conv_step) begin
			bcd_q <= {bcd_adj[bdlw_pkg::BCD_WIDTH-2:0], mag_q[bdlw_pkg::NUM_WIDTH-1]};
			mag_q <= {mag_q[bdlw_pkg::NUM_WIDTH-2:0], 1'b0};
		end
		if (cmd.emit) begin
			out_q <= out_next;
		end
	end

	always_comb begin
		status.sign_draw = sign_draw_q;
		status.mag_zero = mag_zero_q;
		status.pct = pct_q;
		status.last_digit = ({1'b0, cmd.idx} == (n_q - 4'd1));
		status.gaps_none = (n_q == 4'd1) && (sc_q == 8'd0);
		status.sc_zero = (sc_q == 8'd0);
		status.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

@@ sv/bdlw_ctrl.sv @@
// Controller: sequences conversion, glyph writes, percent and gap writes for one transaction.
module bdlw_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input bdlw_pkg::status_t status,
	output bdlw_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_SIGN,
		S_DIGIT,
		S_REPEAT,
		S_PCT,
		S_GAP
	} state_t;

	localparam logic [4:0] CONV_LAST = 5'(bdlw_pkg::NUM_WIDTH - 1);

	state_t state_q;
	logic [4:0] conv_q;
	logic [2:0] idx_q;
	logic [1:0] sub_q;
	logic glyph_end;
	logic [2:0] gap_first;
	logic emitting;

	always_comb begin
		glyph_end = (sub_q == 2'd3);
		gap_first = status.sc_zero ? 3'd1 : 3'd0;
		emitting = (state_q != S_IDLE) && (state_q != S_CONV);
		in_stall = (state_q != S_IDLE);
		cmd.load = in_valid && (state_q == S_IDLE);
		cmd.conv_step = (state_q == S_CONV);
		cmd.emit = emitting && status.out_free;
		cmd.idx = idx_q;
		cmd.sub = sub_q;
		case (state_q)
			S_DIGIT: begin
				cmd.op = bdlw_pkg::OP_DIGIT;
				cmd.last = glyph_end && status.last_digit && !status.mag_zero &&
					!status.pct && status.gaps_none;
			end
			S_REPEAT: begin
				cmd.op = bdlw_pkg::OP_REPEAT;
				cmd.last = glyph_end && !status.pct && status.gaps_none;
			end
			S_PCT: begin
				cmd.op = bdlw_pkg::OP_PCT;
				cmd.last = glyph_end && status.gaps_none;
			end
			S_GAP: begin
				cmd.op = bdlw_pkg::OP_GAP;
				cmd.last = sub_q[0] && status.last_digit;
			end
			default: begin
				cmd.op = bdlw_pkg::OP_SIGN;
				cmd.last = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			conv_q <= 5'd0;
			idx_q <= 3'd0;
			sub_q <= 2'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						conv_q <= 5'd0;
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					conv_q <= conv_q + 5'd1;
					if (conv_q == CONV_LAST) begin
						idx_q <= 3'd0;
						sub_q <= 2'd0;
						state_q <= status.sign_draw ? S_SIGN : S_DIGIT;
					end
				end
				S_SIGN: begin
					if (cmd.emit) begin
						sub_q <= sub_q + 2'd1;
						if (glyph_end) begin
							state_q <= S_DIGIT;
						end
					end
				end
				S_DIGIT: begin
					if (cmd.emit) begin
						sub_q <= sub_q + 2'd1;
						if (glyph_end) begin
							if (!status.last_digit) begin
								idx_q <= idx_q + 3'd1;
							end else if (status.mag_zero) begin
								state_q <= S_REPEAT;
							end else if (status.pct) begin
								state_q <= S_PCT;
							end else if (status.gaps_none) begin
								state_q <= S_IDLE;
							end else begin
								idx_q <= gap_first;
								state_q <= S_GAP;
							end
						end
					end
				end
				S_REPEAT: begin
					if (cmd.emit) begin
						sub_q <= sub_q + 2'd1;
						if (glyph_end) begin
							if (status.pct) begin
								state_q <= S_PCT;
							end else if (status.gaps_none) begin
								state_q <= S_IDLE;
							end else begin
								idx_q <= gap_first;
								state_q <= S_GAP;
							end
						end
					end
				end
				S_PCT: begin
					if (cmd.emit) begin
						sub_q <= sub_q + 2'd1;
						if (glyph_end) begin
							if (status.gaps_none) begin
								state_q <= S_IDLE;
							end else begin
								idx_q <= gap_first;
								state_q <= S_GAP;
							end
						end
					end
				end
				S_GAP: begin
					if (cmd.emit) begin
						if (sub_q[0]) begin
							sub_q <= 2'd0;
							if (status.last_digit) begin
								state_q <= S_IDLE;
							end else begin
								idx_q <= idx_q + 3'd1;
							end
						end else begin
							sub_q <= 2'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/big_digit_lcd_writer.sv @@
// A transaction is taken, its magnitude is converted from binary to BCD, then it causes 4 to 60 cell writes.
// The conversion shifts one magnitude bit per cycle; the output register takes one write per cycle while not stalled.
// The next transaction is taken while the final write still waits in the output register.
// Reset clears the sign history and output valid and loads the configuration defaults.
module big_digit_lcd_writer (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [2:0] cfg_index,
	input logic [7:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input bdlw_pkg::in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output bdlw_pkg::out_t out_data
);

	bdlw_pkg::cmd_t cmd;
	bdlw_pkg::status_t status;

	bdlw_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status(status),
		.cmd(cmd)
	);

	bdlw_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.cmd(cmd),
		.status(status),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule
